### rtl/core/dda_pkg.sv
`default_nettype none
package dda_pkg;

    localparam int COLOR_BITS = 24;

    // opcodes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_PLOT = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef logic [COLOR_BITS-1:0] t_color;

endpackage
`default_nettype wire

### rtl/core/dda_if.sv
`default_nettype none
interface dda_in_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (output valid, opcode, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_out_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [23:0]                  color;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, color, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, color, last, output ready);
endinterface
`default_nettype wire

### rtl/core/dda_front.sv
`default_nettype none
module dda_front
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    dda_in_if.sink     i_in,
    dda_in_if.source   o_cmd
);

    localparam int EW = 2 + 4 * COORD_BITS;

    logic [EW-1:0] r_mem [Q_DEPTH];
    logic [Q_AW:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW:0] r_rd_ptr, n_rd_ptr;
    logic          full;
    logic          empty;
    logic          wr_en;
    logic          rd_en;
    logic [EW-1:0] rd_entry;

    assign full  = (r_wr_ptr[Q_AW] != r_rd_ptr[Q_AW]) &&
                   (r_wr_ptr[Q_AW-1:0] == r_rd_ptr[Q_AW-1:0]);
    assign empty = (r_wr_ptr == r_rd_ptr);

    assign i_in.ready = !full;
    // drop the unused opcode here; it has no effect downstream
    assign wr_en = i_in.valid && !full && (i_in.opcode != OP_NONE);
    assign rd_en = o_cmd.ready && !empty;

    assign n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
    assign n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr[Q_AW-1:0]] <= {i_in.opcode, i_in.x_start, i_in.y_start,
                                          i_in.x_end, i_in.y_end};
        end
    end

    assign rd_entry = r_mem[r_rd_ptr[Q_AW-1:0]];

    assign o_cmd.valid   = !empty;
    assign o_cmd.opcode  = rd_entry[EW-1 -: 2];
    assign o_cmd.x_start = rd_entry[4*COORD_BITS-1 -: COORD_BITS];
    assign o_cmd.y_start = rd_entry[3*COORD_BITS-1 -: COORD_BITS];
    assign o_cmd.x_end   = rd_entry[2*COORD_BITS-1 -: COORD_BITS];
    assign o_cmd.y_end   = rd_entry[COORD_BITS-1 -: COORD_BITS];

endmodule
`default_nettype wire

### rtl/core/dda_div.sv
`default_nettype none
module dda_div
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [COORD_BITS-1:0] i_ax,
    input  wire  [COORD_BITS-1:0] i_ay,
    input  wire  [COORD_BITS-1:0] i_len,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_qx,
    output logic [FRAC_BITS:0]    o_qy
);

    // restoring division of (a << FRAC_BITS) by len, one quotient bit per cycle;
    // a <= len, so the first bit is the integer part
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic                  r_first;
    logic [CW-1:0]         r_cnt;
    logic [COORD_BITS:0]   r_rem_x, r_rem_y;
    logic [FRAC_BITS:0]    r_q_x, r_q_y;
    logic [COORD_BITS:0]   r_len_q;
    logic [COORD_BITS:0]   trial_x, trial_y;
    logic [COORD_BITS:0]   len_ext;
    logic                  ge_x, ge_y;

    assign len_ext = {1'b0, i_len};
    assign trial_x = r_first ? r_rem_x : {r_rem_x[COORD_BITS-1:0], 1'b0};
    assign trial_y = r_first ? r_rem_y : {r_rem_y[COORD_BITS-1:0], 1'b0};
    assign ge_x    = trial_x >= r_len_q;
    assign ge_y    = trial_y >= r_len_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_len_q <= len_ext;
            r_rem_x <= {1'b0, i_ax};
            r_rem_y <= {1'b0, i_ay};
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_first <= 1'b1;
            r_cnt   <= CW'(FRAC_BITS);
        end else if (r_busy) begin
            r_rem_x <= ge_x ? trial_x - r_len_q : trial_x;
            r_rem_y <= ge_y ? trial_y - r_len_q : trial_y;
            r_q_x   <= {r_q_x[FRAC_BITS-1:0], ge_x};
            r_q_y   <= {r_q_y[FRAC_BITS-1:0], ge_y};
            r_first <= 1'b0;
            r_cnt   <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_qx   = r_q_x;
    assign o_qy   = r_q_y;

endmodule
`default_nettype wire

### rtl/core/dda_back.sv
`default_nettype none
module dda_back
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [COLOR_BITS-1:0] i_cfg_data,
    dda_in_if.sink                i_cmd,
    dda_out_if.source             o_pix
);

    localparam int AW = COORD_BITS + FRAC_BITS;
    localparam int SW = FRAC_BITS + 2;
    localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic                  r_state, n_state;
    t_color                r_pen;
    logic [AW-1:0]         r_x_acc, n_x_acc;
    logic [AW-1:0]         r_y_acc, n_y_acc;
    logic signed [SW-1:0]  r_x_step, n_x_step;
    logic signed [SW-1:0]  r_y_step, n_y_step;
    logic [COORD_BITS-1:0] r_left, n_left;
    logic [COORD_BITS-1:0] r_x_base, n_x_base;
    logic [COORD_BITS-1:0] r_y_base, n_y_base;
    logic                  r_x_neg, n_x_neg;
    logic                  r_y_neg, n_y_neg;

    logic                  r_out_valid, n_out_valid;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;
    t_color                r_out_color, n_out_color;
    logic                  r_out_last, n_out_last;

    logic                  out_free;
    logic                  cmd_fire;
    logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
    logic [COORD_BITS-1:0] ax, ay, len;
    logic [AW-1:0]         x_base, y_base;
    logic                  div_start;
    logic                  div_done;
    logic [FRAC_BITS:0]    qx, qy;
    logic signed [SW-1:0]  qx_ext, qy_ext;

    assign out_free    = !r_out_valid || o_pix.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && out_free;
    assign cmd_fire    = i_cmd.valid && i_cmd.ready;

    // major-axis length from the endpoint differences
    assign dx     = {i_cmd.x_end[COORD_BITS-1], i_cmd.x_end}
                  - {i_cmd.x_start[COORD_BITS-1], i_cmd.x_start};
    assign dy     = {i_cmd.y_end[COORD_BITS-1], i_cmd.y_end}
                  - {i_cmd.y_start[COORD_BITS-1], i_cmd.y_start};
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    assign ax     = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ay     = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    assign len    = (ax >= ay) ? ax : ay;

    assign div_start = cmd_fire && (i_cmd.opcode == OP_LOAD) && (len != '0);

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ax    (ax),
        .i_ay    (ay),
        .i_len   (len),
        .o_done  (div_done),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    assign qx_ext = {1'b0, qx};
    assign qy_ext = {1'b0, qy};
    assign x_base = {r_x_base, {FRAC_BITS{1'b0}}};
    assign y_base = {r_y_base, {FRAC_BITS{1'b0}}};

    always_comb begin
        n_state     = r_state;
        n_x_acc     = r_x_acc;
        n_y_acc     = r_y_acc;
        n_x_step    = r_x_step;
        n_y_step    = r_y_step;
        n_left      = r_left;
        n_x_base    = r_x_base;
        n_y_base    = r_y_base;
        n_x_neg     = r_x_neg;
        n_y_neg     = r_y_neg;
        n_out_valid = r_out_valid && !o_pix.ready;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_fire) begin
                    unique case (i_cmd.opcode)
                        OP_LOAD: begin
                            n_x_base = i_cmd.x_start;
                            n_y_base = i_cmd.y_start;
                            n_x_neg  = dx[COORD_BITS];
                            n_y_neg  = dy[COORD_BITS];
                            n_left   = len;
                            if (len == '0) begin
                                // zero step counts as positive
                                n_x_step = '0;
                                n_y_step = '0;
                                n_x_acc  = {i_cmd.x_start, {FRAC_BITS{1'b0}}} + HALF;
                                n_y_acc  = {i_cmd.y_start, {FRAC_BITS{1'b0}}} + HALF;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        OP_TICK: begin
                            if (r_left != '0) begin
                                n_out_valid = 1'b1;
                                n_out_x     = r_x_acc[AW-1:FRAC_BITS];
                                n_out_y     = r_y_acc[AW-1:FRAC_BITS];
                                n_out_color = r_pen;
                                n_out_last  = (r_left == COORD_BITS'(1));
                                n_x_acc     = r_x_acc + AW'(r_x_step);
                                n_y_acc     = r_y_acc + AW'(r_y_step);
                                n_left      = r_left - 1'b1;
                            end
                        end
                        OP_PLOT: begin
                            n_out_valid = 1'b1;
                            n_out_x     = i_cmd.x_start;
                            n_out_y     = i_cmd.y_start;
                            n_out_color = '0;
                            n_out_last  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_x_step = r_x_neg ? -qx_ext : qx_ext;
                    n_y_step = r_y_neg ? -qy_ext : qy_ext;
                    // half pixel back only when the step really is negative
                    n_x_acc  = (r_x_neg && qx != '0) ? x_base - HALF : x_base + HALF;
                    n_y_acc  = (r_y_neg && qy != '0) ? y_base - HALF : y_base + HALF;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_pen       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            if (i_cfg_we) begin
                r_pen <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_acc     <= n_x_acc;
        r_y_acc     <= n_y_acc;
        r_x_step    <= n_x_step;
        r_y_step    <= n_y_step;
        r_x_base    <= n_x_base;
        r_y_base    <= n_y_base;
        r_x_neg     <= n_x_neg;
        r_y_neg     <= n_y_neg;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_pix.valid   = r_out_valid;
    assign o_pix.pixel_x = r_out_x;
    assign o_pix.pixel_y = r_out_y;
    assign o_pix.color   = r_out_color;
    assign o_pix.last    = r_out_last;

endmodule
`default_nettype wire

### rtl/core/dda_line_rasterizer.sv
`default_nettype none
// DDA line rasterizer. A load command latches a segment and works out the
// per-pixel steps with a bit-serial divider: the stepping unit takes no other
// command until the division is done, and the load emits nothing. Each tick
// then gives one pixel per cycle while the output is not stalled, in the pen
// colour, with last on the final pixel of the segment; the far endpoint is not
// drawn and a zero-length segment draws nothing. A plot command gives one
// black pixel, last set. A four-entry command queue sits in front of the
// stepping unit, so input is taken while a load is being divided or the
// output is stalled. Write the pen colour only while the block is idle.
module dda_line_rasterizer
    import dda_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire  [COLOR_BITS-1:0] i_cfg_data,
    dda_in_if.sink                i_in,
    dda_out_if.source             o_out
);

    dda_in_if #(.COORD_BITS(COORD_BITS)) cmd_q ();

    dda_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_cmd   (cmd_q)
    );

    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_q),
        .o_pix      (o_out)
    );

endmodule
`default_nettype wire
